FILE: src/i2cmbe_pkg.sv
`timescale 1ns / 1ps

package i2cmbe_pkg;

    // Default word length of one byte transfer on the bus
    localparam int BITS_PER_WORD_DEF = 8;

    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int TIMEOUT_W = 10;
    localparam int DELAY_W   = 16;
    localparam int PHASE_W   = 3;

    // Command codes on the op field
    localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
    localparam logic [OP_W-1:0] OP_START   = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_ACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_RD_NACK = 3'd5;

    // Configuration register indexes
    localparam logic CFG_ACK_TIMEOUT = 1'b0;
    localparam logic CFG_TICKS       = 1'b1;

    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 10'd50;
    localparam logic [DELAY_W-1:0]   TICKS_RST       = 16'd1;

    // Phase where a write polls for the slave acknowledge
    localparam logic [PHASE_W-1:0] PH_ACK_POLL = 3'd6;

    typedef enum logic [5:0] {
        CMD_IDLE    = 6'b000001,
        CMD_START   = 6'b000010,
        CMD_STOP    = 6'b000100,
        CMD_WRITE   = 6'b001000,
        CMD_RD_ACK  = 6'b010000,
        CMD_RD_NACK = 6'b100000
    } cmd_t;

    // Sequencer state that does not depend on the word length
    typedef struct packed {
        cmd_t                 cmd;
        logic [PHASE_W-1:0]   phase;
        logic [DELAY_W-1:0]   delay;
        logic [TIMEOUT_W-1:0] ack_wait;
        logic                 scl;
        logic                 sda;
        logic [1:0]           status;   // bit0 ack_ok, bit1 timed_out
        logic [BYTE_W-1:0]    rx_hold;
    } ctl_t;

    // One result beat
    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              cmd_done;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_ok;
        logic              timed_out;
    } res_t;

    function automatic cmd_t op_to_cmd(input logic [OP_W-1:0] op);
        cmd_t c;
        c = CMD_IDLE;
        unique case (op)
            OP_START:   c = CMD_START;
            OP_STOP:    c = CMD_STOP;
            OP_WRITE:   c = CMD_WRITE;
            OP_RD_ACK:  c = CMD_RD_ACK;
            OP_RD_NACK: c = CMD_RD_NACK;
            default:    c = CMD_IDLE;
        endcase
        return c;
    endfunction

endpackage

FILE: src/i2c_master_byte_engine_unit.sv
`timescale 1ns / 1ps

// I2C master byte engine. Each input beat is one timing tick of the bus
// sequencer: it carries a sampled SDA level and, while the engine is idle, an
// optional command (start, stop, write a byte and check the acknowledge, read
// a byte and answer ACK or NACK). Every tick yields exactly one result beat
// with the SCL and SDA drive levels, busy, done, the last received byte and
// the ack and timeout status. One tick is taken every clock cycle while the
// consumer keeps out_ready high; the tick is held in the input register, and
// the sequencer state is updated in the single pass from there into the
// result register, which offers the tick's result beat. Bus delay phases are
// counted in ticks (ticks_per_delay, zero taken as one), not in clock cycles.
// A missing acknowledge after ack_timeout+1 high polls makes the engine issue
// a stop and report timed_out. Reset gives the engine idle with both lines
// released and needs no clearing pass. Write configuration only while no tick
// is in flight.

module i2c_master_byte_engine_unit import i2cmbe_pkg::*; #(
    parameter int BITS_PER_WORD = BITS_PER_WORD_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [DELAY_W-1:0]   cfg_wdata,
    // tick channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [OP_W-1:0]      op,
    input  logic [BYTE_W-1:0]    tx_byte,
    input  logic                 sda_in,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 scl_level,
    output logic                 sda_level,
    output logic                 busy_res,
    output logic                 cmd_done,
    output logic [BYTE_W-1:0]    rx_byte,
    output logic                 ack_ok,
    output logic                 timed_out
);

    localparam int BW   = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
    localparam int IN_W = OP_W + BYTE_W + 1;
    localparam int RES_W = $bits(res_t);

    // Configuration registers
    logic [TIMEOUT_W-1:0] ack_timeout_reg;
    logic [DELAY_W-1:0]   ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            ticks_reg       <= TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_TICKS:       ticks_reg       <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Input register: hold the tick until the result register can take it
    logic              t_valid;
    logic              t_ready;
    logic [IN_W-1:0]   t_data;
    logic [OP_W-1:0]   t_op;
    logic [BYTE_W-1:0] t_tx;
    logic              t_sda;

    i2cmbe_pipe_reg #(
        .WIDTH (IN_W)
    ) u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   ({op, tx_byte, sda_in}),
        .out_valid (t_valid),
        .out_ready (t_ready),
        .out_data  (t_data)
    );

    assign {t_op, t_tx, t_sda} = t_data;

    // Sequencer state, advanced once for every tick that moves on
    ctl_t                     ctl_reg;
    ctl_t                     ctl_next;
    logic [BW-1:0]            bit_reg;
    logic [BW-1:0]            bit_next;
    logic [BITS_PER_WORD-1:0] shift_reg;
    logic [BITS_PER_WORD-1:0] shift_next;
    res_t                     res;
    logic                     tick_fire;

    i2cmbe_step #(
        .BITS_PER_WORD (BITS_PER_WORD)
    ) u_step (
        .ack_timeout     (ack_timeout_reg),
        .ticks_per_delay (ticks_reg),
        .op              (t_op),
        .tx_byte         (t_tx),
        .sda_in          (t_sda),
        .ctl_cur         (ctl_reg),
        .bit_cur         (bit_reg),
        .shift_cur       (shift_reg),
        .ctl_next        (ctl_next),
        .bit_next        (bit_next),
        .shift_next      (shift_next),
        .res             (res)
    );

    assign tick_fire = t_valid && t_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.cmd      <= CMD_IDLE;
            ctl_reg.phase    <= '0;
            ctl_reg.delay    <= '0;
            ctl_reg.ack_wait <= '0;
            ctl_reg.scl      <= 1'b1;
            ctl_reg.sda      <= 1'b1;
            ctl_reg.status   <= 2'b00;
            ctl_reg.rx_hold  <= '0;
            bit_reg          <= '0;
            shift_reg        <= '0;
        end
        else if (tick_fire)
        begin
            ctl_reg   <= ctl_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
        end
    end

    // Result register: parts the tick side from a stalled consumer
    logic [RES_W-1:0] r_data;
    res_t             r_res;

    i2cmbe_pipe_reg #(
        .WIDTH (RES_W)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .in_ready  (t_ready),
        .in_data   (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (r_data)
    );

    assign r_res     = r_data;
    assign scl_level = r_res.scl_level;
    assign sda_level = r_res.sda_level;
    assign busy_res  = r_res.busy_res;
    assign cmd_done  = r_res.cmd_done;
    assign rx_byte   = r_res.rx_byte;
    assign ack_ok    = r_res.ack_ok;
    assign timed_out = r_res.timed_out;

    // A finished command leaves the engine idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd_done |-> !busy_res)
    else $error("done reported while still busy");

    // Idle sequencer holds no phase and no pending delay
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.cmd == CMD_IDLE |-> ctl_reg.phase == '0 && ctl_reg.delay == '0)
    else $error("idle with phase or delay left over");

    // Any running phase has a loaded delay count
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg.cmd != CMD_IDLE |-> ctl_reg.delay != '0)
    else $error("active command with empty delay count");

    // Bit counter stays within the word
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, bit_reg} < (BW + 1)'(BITS_PER_WORD))
    else $error("bit index beyond word length");

    // Ack and timeout status never both set
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl_reg.status[0] && ctl_reg.status[1]))
    else $error("ack_ok and timed_out both set");

endmodule

FILE: src/i2cmbe_pipe_reg.sv
`timescale 1ns / 1ps

module i2cmbe_pipe_reg import i2cmbe_pkg::*; #(
    parameter int WIDTH = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    // Take a new beat whenever the held one is empty or leaves this cycle
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/i2cmbe_step.sv
`timescale 1ns / 1ps

module i2cmbe_step import i2cmbe_pkg::*; #(
    parameter int BITS_PER_WORD = BITS_PER_WORD_DEF,
    localparam int BW = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1
) (
    input  logic [TIMEOUT_W-1:0]     ack_timeout,
    input  logic [DELAY_W-1:0]       ticks_per_delay,
    input  logic [OP_W-1:0]          op,
    input  logic [BYTE_W-1:0]        tx_byte,
    input  logic                     sda_in,
    input  ctl_t                     ctl_cur,
    input  logic [BW-1:0]            bit_cur,
    input  logic [BITS_PER_WORD-1:0] shift_cur,
    output ctl_t                     ctl_next,
    output logic [BW-1:0]            bit_next,
    output logic [BITS_PER_WORD-1:0] shift_next,
    output res_t                     res
);

    localparam logic [BW-1:0] TOP_BIT  = BW'(BITS_PER_WORD - 1);
    localparam logic [BW:0]   WORD_LEN = (BW + 1)'(BITS_PER_WORD);

    always_comb
    begin
        logic               do_enter;
        logic               fin;
        logic               done;
        logic [PHASE_W-1:0] ph;
        logic [BW:0]        bit_inc;
        logic [DELAY_W-1:0] tpd_eff;

        ctl_next   = ctl_cur;
        bit_next   = bit_cur;
        shift_next = shift_cur;
        do_enter   = 1'b0;
        fin        = 1'b0;
        done       = 1'b0;
        ph         = '0;
        bit_inc    = {1'b0, bit_cur} + (BW + 1)'(1);
        tpd_eff    = (ticks_per_delay == '0) ? DELAY_W'(1) : ticks_per_delay;

        if (ctl_cur.cmd == CMD_IDLE)
        begin
            if (op >= OP_START && op <= OP_RD_NACK)
            begin
                ctl_next.cmd       = op_to_cmd(op);
                bit_next           = '0;
                ctl_next.ack_wait  = '0;
                ctl_next.status[1] = 1'b0;
                if (op == OP_WRITE)
                begin
                    ctl_next.status = 2'b00;
                    shift_next      = BITS_PER_WORD'(tx_byte);
                end
                else if (op == OP_RD_ACK || op == OP_RD_NACK)
                begin
                    shift_next = '0;
                end
                do_enter = 1'b1;
            end
        end
        else if (ctl_cur.cmd == CMD_WRITE && ctl_cur.phase == PH_ACK_POLL)
        begin
            // Poll every tick, no delay count
            do_enter = 1'b1;
            ph       = PH_ACK_POLL;
        end
        else if (ctl_cur.delay > DELAY_W'(1))
        begin
            ctl_next.delay = ctl_cur.delay - DELAY_W'(1);
        end
        else
        begin
            do_enter = 1'b1;
            if (ctl_cur.phase == 3'd2 && ctl_cur.cmd != CMD_START
                && ctl_cur.cmd != CMD_STOP && bit_inc < WORD_LEN)
            begin
                bit_next = bit_inc[BW-1:0];
                ph       = '0;
            end
            else
            begin
                ph = ctl_cur.phase + PHASE_W'(1);
            end
        end

        if (do_enter)
        begin
            ctl_next.phase = ph;
            ctl_next.delay = tpd_eff;
            unique case (ctl_next.cmd)
                CMD_START:
                begin
                    priority if (ph == 3'd0)
                    begin
                        ctl_next.sda = 1'b1;
                        ctl_next.scl = 1'b1;
                    end
                    else if (ph == 3'd1)
                        ctl_next.sda = 1'b0;
                    else if (ph == 3'd2)
                        ctl_next.scl = 1'b0;
                    else
                        fin = 1'b1;
                end
                CMD_STOP:
                begin
                    priority if (ph == 3'd0)
                    begin
                        ctl_next.scl = 1'b0;
                        ctl_next.sda = 1'b0;
                    end
                    else if (ph == 3'd1)
                        ctl_next.scl = 1'b1;
                    else
                    begin
                        ctl_next.sda = 1'b1;
                        fin          = 1'b1;
                    end
                end
                CMD_WRITE:
                begin
                    priority if (ph == 3'd0)
                    begin
                        ctl_next.scl = 1'b0;
                        ctl_next.sda = shift_next[TOP_BIT - bit_next];
                    end
                    else if (ph == 3'd1 || ph == 3'd4)
                        ctl_next.scl = 1'b1;
                    else if (ph == 3'd2)
                        ctl_next.scl = 1'b0;
                    else if (ph == 3'd3)
                        ctl_next.sda = 1'b1;
                    else if (ph == PH_ACK_POLL)
                    begin
                        priority if (!sda_in)
                        begin
                            ctl_next.scl       = 1'b0;
                            ctl_next.status[0] = 1'b1;
                            fin                = 1'b1;
                        end
                        else if (ctl_cur.ack_wait >= ack_timeout)
                        begin
                            // No acknowledge: drop into a full stop sequence
                            ctl_next.status   = 2'b10;
                            ctl_next.cmd      = CMD_STOP;
                            ctl_next.ack_wait = '0;
                            ctl_next.phase    = '0;
                            ctl_next.scl      = 1'b0;
                            ctl_next.sda      = 1'b0;
                        end
                        else
                            ctl_next.ack_wait = ctl_cur.ack_wait + TIMEOUT_W'(1);
                    end
                    else
                    begin
                        // hold phase: lines unchanged
                    end
                end
                CMD_RD_ACK, CMD_RD_NACK:
                begin
                    priority if (ph == 3'd0)
                        ctl_next.scl = 1'b0;
                    else if (ph == 3'd1)
                    begin
                        ctl_next.scl = 1'b1;
                        ctl_next.sda = 1'b1;
                    end
                    else if (ph == 3'd2)
                        shift_next = (shift_next << 1) | BITS_PER_WORD'(sda_in);
                    else if (ph == 3'd3)
                    begin
                        ctl_next.scl = 1'b0;
                        ctl_next.sda = (ctl_next.cmd == CMD_RD_ACK) ? 1'b0 : 1'b1;
                    end
                    else if (ph == 3'd4)
                        ctl_next.scl = 1'b1;
                    else
                    begin
                        ctl_next.scl = 1'b0;
                        fin          = 1'b1;
                    end
                end
                default:
                    fin = 1'b1;
            endcase

            if (fin)
            begin
                if (ctl_next.cmd == CMD_RD_ACK || ctl_next.cmd == CMD_RD_NACK)
                    ctl_next.rx_hold = BYTE_W'(shift_next);
                ctl_next.cmd   = CMD_IDLE;
                ctl_next.phase = '0;
                ctl_next.delay = '0;
                bit_next       = '0;
                done           = 1'b1;
            end
        end

        res.scl_level = ctl_next.scl;
        res.sda_level = ctl_next.sda;
        res.busy_res  = (ctl_next.cmd != CMD_IDLE);
        res.cmd_done  = done;
        res.rx_byte   = ctl_next.rx_hold;
        res.ack_ok    = ctl_next.status[0];
        res.timed_out = ctl_next.status[1];
    end

endmodule
